FILE: hw/rtl/button_debounce_fsm_defines.svh
`ifndef BUTTON_DEBOUNCE_FSM_DEFINES_SVH
`define BUTTON_DEBOUNCE_FSM_DEFINES_SVH

// a holds in this cycle, so b holds in the next one
`define DBF_ASSERT_NEXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error(msg);

// a implies b in the same cycle
`define DBF_ASSERT_NOW(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error(msg);

`endif

FILE: hw/rtl/dbf_pkg.sv
`timescale 1ns / 1ps

package dbf_pkg;

	localparam int CODE_BITS     = 10;
	localparam int TIME_BITS     = 48;
	localparam int TMO_BITS      = 20;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 20;
	localparam int MAX_NOTES     = 3;
	localparam int NOTE_CNT_BITS = 2;

	localparam logic [TMO_BITS-1:0] LONG_TMO_RST  = TMO_BITS'(25000);
	localparam logic [TMO_BITS-1:0] SHORT_TMO_RST = TMO_BITS'(12000);

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_TMO  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_TMO = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEB_OFF   = 2'd2;

	// request kinds
	localparam logic FUNC_CHANGE = 1'b0;
	localparam logic FUNC_CHECK  = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [CODE_BITS-1:0] key_code;
		logic                 is_down;
		logic                 several;
		logic                 first_in_frame;
		logic [TIME_BITS-1:0] time_now;
	} item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] notice_code;
		logic                 pressed;
		logic [TIME_BITS-1:0] notice_time;
		logic                 last;
	} notice_t;

	// all notices caused by one request, in order from index 0
	typedef struct packed {
		logic [NOTE_CNT_BITS-1:0]      count;
		notice_t [MAX_NOTES-1:0]       items;
	} bundle_t;

endpackage

FILE: hw/rtl/dbf_core.sv
`timescale 1ns / 1ps

module dbf_core import dbf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  item_t                    item,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     can_load,
	output logic                     bundle_valid,
	output bundle_t                  bundle
);

	typedef enum logic [3:0] {
		ST_UP             = 4'd0,
		ST_DOWN           = 4'd1,
		ST_DOWN_WAIT      = 4'd2,
		ST_UP_DELAY       = 4'd3,
		ST_UP_DELAY_SP    = 4'd4,
		ST_UP_DETECT_SP   = 4'd5,
		ST_DOWN_DETECT_SP = 4'd6,
		ST_UP_WAIT        = 4'd7,
		ST_DOWN_DELAY     = 4'd8,
		ST_DISABLED       = 4'd9
	} st_t;

	typedef enum logic [2:0] {
		EV_PRESS, EV_RELEASE, EV_LONG, EV_SHORT, EV_OTHER
	} ev_t;

	typedef struct packed {
		st_t                  fsm;
		logic                 spurious_on;
		logic [CODE_BITS-1:0] held_code;
		logic [TIME_BITS-1:0] held_time;
		logic                 long_armed;
		logic [TIME_BITS-1:0] long_deadline;
		logic                 short_armed;
		logic [TIME_BITS-1:0] short_deadline;
	} dbs_t;

	typedef struct packed {
		dbs_t s;
		logic note;
		logic pr;
	} hres_t;

	function automatic hres_t handle(input dbs_t s_in, input ev_t ev,
			input logic [TIME_BITS-1:0] t, input logic [TIME_BITS-1:0] lsum,
			input logic [TIME_BITS-1:0] ssum);
		hres_t r;
		r.s = s_in;
		r.note = 1'b0;
		r.pr = 1'b0;
		if (ev == EV_OTHER) begin
			r.s.long_armed = 1'b0;
			r.s.short_armed = 1'b0;
		end
		unique case (s_in.fsm)
			ST_UP: begin
				if (ev == EV_PRESS) begin
					r.s.held_time = t;
					r.s.long_armed = 1'b1;
					r.s.long_deadline = lsum;
					r.s.fsm = ST_DOWN_WAIT;
					r.note = 1'b1;
					r.pr = 1'b1;
				end
			end
			ST_DOWN: begin
				if (ev == EV_RELEASE) begin
					r.s.held_time = t;
					r.s.long_armed = 1'b1;
					r.s.long_deadline = lsum;
					r.s.short_armed = 1'b1;
					r.s.short_deadline = ssum;
					if (s_in.spurious_on) begin
						r.s.fsm = ST_UP_DELAY_SP;
					end else begin
						r.s.fsm = ST_UP_DETECT_SP;
						r.note = 1'b1;
					end
				end
			end
			ST_DOWN_WAIT: begin
				if (ev == EV_RELEASE) begin
					r.s.fsm = ST_UP_DELAY;
					r.s.held_time = t;
				end else if (ev == EV_LONG || ev == EV_OTHER) begin
					r.s.fsm = ST_DOWN;
				end
			end
			ST_UP_DELAY: begin
				if (ev == EV_PRESS) begin
					r.s.fsm = ST_DOWN_WAIT;
				end else if (ev == EV_LONG || ev == EV_OTHER) begin
					r.s.fsm = ST_UP;
					r.note = 1'b1;
				end
			end
			ST_UP_DELAY_SP: begin
				if (ev == EV_PRESS) begin
					r.s.fsm = ST_DOWN;
					r.s.long_armed = 1'b0;
					r.s.short_armed = 1'b0;
				end else if (ev == EV_SHORT) begin
					r.s.fsm = ST_UP_WAIT;
					r.note = 1'b1;
				end else if (ev == EV_OTHER) begin
					r.s.fsm = ST_UP;
					r.note = 1'b1;
				end
			end
			ST_UP_DETECT_SP: begin
				if (ev == EV_PRESS) begin
					r.s.held_time = t;
					r.s.fsm = ST_DOWN_DETECT_SP;
				end else if (ev == EV_LONG || ev == EV_OTHER) begin
					r.s.fsm = ST_UP;
				end else if (ev == EV_SHORT) begin
					r.s.fsm = ST_UP_WAIT;
				end
			end
			ST_DOWN_DETECT_SP: begin
				if (ev == EV_RELEASE) begin
					r.s.fsm = ST_UP_DETECT_SP;
				end else if (ev == EV_SHORT) begin
					r.s.long_armed = 1'b0;
					r.s.fsm = ST_DOWN;
					r.s.spurious_on = 1'b1;
					r.note = 1'b1;
					r.pr = 1'b1;
				end else if (ev == EV_LONG || ev == EV_OTHER) begin
					r.s.fsm = ST_DOWN;
					r.note = 1'b1;
					r.pr = 1'b1;
				end
			end
			ST_UP_WAIT: begin
				if (ev == EV_PRESS) begin
					r.s.held_time = t;
					r.s.fsm = ST_DOWN_DELAY;
				end else if (ev == EV_LONG || ev == EV_OTHER) begin
					r.s.fsm = ST_UP;
				end
			end
			ST_DOWN_DELAY: begin
				if (ev == EV_RELEASE) begin
					r.s.fsm = ST_UP_WAIT;
				end else if (ev == EV_LONG || ev == EV_OTHER) begin
					r.s.fsm = ST_DOWN;
					r.note = 1'b1;
					r.pr = 1'b1;
				end
			end
			ST_DISABLED: begin
				if (ev == EV_PRESS || ev == EV_RELEASE) begin
					r.s.held_time = t;
					r.note = 1'b1;
					r.pr = (ev == EV_PRESS);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	logic                valid_s1;
	item_t               item_s1;
	dbs_t                st_q;
	logic [TMO_BITS-1:0] long_tmo_q;
	logic [TMO_BITS-1:0] short_tmo_q;
	logic                deb_off_q;

	logic [TIME_BITS-1:0] t, lsum, ssum;
	logic                 flush_pre, fire_s, fire_l;
	dbs_t                 s_a, s_b, s_c, s_next;
	hres_t                h1, h2, h3, t1, t2;
	hres_t [MAX_NOTES-1:0] slot;

	assign bundle_valid = valid_s1 && can_load;
	assign item_ready   = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_tmo_q  <= LONG_TMO_RST;
			short_tmo_q <= SHORT_TMO_RST;
			deb_off_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LONG_TMO:  long_tmo_q  <= cfg_data;
				CFG_SHORT_TMO: short_tmo_q <= cfg_data;
				CFG_DEB_OFF:   deb_off_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign t    = item_s1.time_now;
	assign lsum = t + TIME_BITS'(long_tmo_q);
	assign ssum = t + TIME_BITS'(short_tmo_q);

	// button change: flush before if needed, the event, flush after for a several-button item
	always_comb begin
		flush_pre = item_s1.first_in_frame
			&& (item_s1.several || item_s1.key_code != st_q.held_code);
		h1.s = st_q;
		h1.note = 1'b0;
		h1.pr = 1'b0;
		if (flush_pre) begin
			h1 = handle(st_q, EV_OTHER, t, lsum, ssum);
		end
		s_a = h1.s;
		// a later item of a several-button frame was flushed by the one before
		if ((flush_pre || (!item_s1.first_in_frame && item_s1.several))
				&& s_a.fsm != ST_DISABLED) begin
			s_a.fsm = item_s1.is_down ? ST_UP : ST_DOWN;
		end
		s_a.held_code = item_s1.key_code;
		h2 = handle(s_a, item_s1.is_down ? EV_PRESS : EV_RELEASE, t, lsum, ssum);
		h3.s = h2.s;
		h3.note = 1'b0;
		h3.pr = 1'b0;
		if (item_s1.several) begin
			h3 = handle(h2.s, EV_OTHER, t, lsum, ssum);
		end
	end

	// time check: short deadline first, then long
	always_comb begin
		fire_s = st_q.short_armed && (t >= st_q.short_deadline);
		s_b = st_q;
		t1.s = st_q;
		t1.note = 1'b0;
		t1.pr = 1'b0;
		if (fire_s) begin
			s_b.short_armed = 1'b0;
			t1 = handle(s_b, EV_SHORT, t, lsum, ssum);
		end
		s_c = t1.s;
		// the short event never rearms the long deadline, only disarms it
		fire_l = s_c.long_armed && (t >= st_q.long_deadline);
		t2.s = s_c;
		t2.note = 1'b0;
		t2.pr = 1'b0;
		if (fire_l) begin
			s_c.long_armed = 1'b0;
			t2 = handle(s_c, EV_LONG, t, lsum, ssum);
		end
	end

	always_comb begin
		if (item_s1.func == FUNC_CHECK) begin
			slot[0] = t1;
			slot[1] = t2;
			slot[2].s = t2.s;
			slot[2].note = 1'b0;
			slot[2].pr = 1'b0;
			s_next = t2.s;
		end else begin
			slot[0] = h1;
			slot[1] = h2;
			slot[2] = h3;
			s_next = h3.s;
		end
	end

	// pack the notices that fired, in order
	always_comb begin
		logic [NOTE_CNT_BITS-1:0] n;
		n = '0;
		bundle = '0;
		for (int i = 0; i < MAX_NOTES; i++) begin
			if (slot[i].note) begin
				bundle.items[n].notice_code = slot[i].s.held_code;
				bundle.items[n].pressed     = slot[i].pr;
				bundle.items[n].notice_time = slot[i].s.held_time;
				bundle.items[n].last        = 1'b0;
				n = n + 1'b1;
			end
		end
		bundle.count = n;
		if (n != '0) begin
			bundle.items[NOTE_CNT_BITS'(n - 1'b1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.fsm            <= ST_UP;
			st_q.spurious_on    <= 1'b0;
			st_q.held_code      <= '0;
			st_q.held_time      <= '0;
			st_q.long_armed     <= 1'b0;
			st_q.long_deadline  <= '0;
			st_q.short_armed    <= 1'b0;
			st_q.short_deadline <= '0;
		end else if (bundle_valid) begin
			st_q <= s_next;
		end else if (cfg_we && cfg_idx == CFG_DEB_OFF && cfg_data[0] != deb_off_q) begin
			if (cfg_data[0]) begin
				st_q.fsm         <= ST_DISABLED;
				st_q.long_armed  <= 1'b0;
				st_q.short_armed <= 1'b0;
			end else if (st_q.fsm == ST_DISABLED) begin
				st_q.fsm <= ST_UP;
			end
		end
	end

endmodule

FILE: hw/rtl/dbf_notice_q.sv
`timescale 1ns / 1ps

module dbf_notice_q import dbf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    bundle_valid,
	input  bundle_t bundle,
	output logic    can_load,
	output logic    notice_valid,
	input  logic    notice_ready,
	output notice_t notice
);

	logic [NOTE_CNT_BITS-1:0] cnt_q;
	notice_t                  entry_q [MAX_NOTES];
	logic                     pop;

	assign notice_valid = (cnt_q != '0);
	assign notice       = entry_q[0];
	assign pop          = notice_valid && notice_ready;
	// a new bundle may land once the last pending notice leaves
	assign can_load     = (cnt_q == '0) || (cnt_q == NOTE_CNT_BITS'(1) && notice_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (bundle_valid) begin
			cnt_q <= bundle.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle_valid) begin
			for (int i = 0; i < MAX_NOTES; i++) begin
				entry_q[i] <= bundle.items[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_NOTES - 1; i++) begin
				entry_q[i] <= entry_q[i+1];
			end
		end
	end

endmodule

FILE: hw/rtl/button_debounce_fsm.sv
`timescale 1ns / 1ps

// Button debounce with spurious-release filter. Each request is a button change or a time
// check; the block answers with zero to three press/release notices, the final one flagged
// by last. A request enters an input register and is evaluated combinationally against the
// debounce state, which then commits; its notices go to a three-entry output queue that
// sends one notice per cycle while notice_ready is high. The queue's single output sets the
// pace: a request's notices load from the input register into the queue only once the last
// pending notice leaves. Requests are taken while notices still wait. The user must write
// registers only while no request is in flight; the block itself does not enforce this.
module button_debounce_fsm import dbf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  item_t                    item,
	output logic                     notice_valid,
	input  logic                     notice_ready,
	output notice_t                  notice,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic    can_load;
	logic    bundle_valid;
	bundle_t bundle;

	dbf_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.can_load     (can_load),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	dbf_notice_q u_notice_q (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.can_load     (can_load),
		.notice_valid (notice_valid),
		.notice_ready (notice_ready),
		.notice       (notice)
	);

endmodule

FILE: hw/rtl/dbf_checker.sv
`timescale 1ns / 1ps

`include "button_debounce_fsm_defines.svh"

module dbf_checker import dbf_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_ready,
	input logic                     notice_valid,
	input logic                     notice_ready,
	input notice_t                  notice
);

	`DBF_ASSERT_NEXT(a_notice_hold, notice_valid && !notice_ready, notice_valid, "notice dropped while stalled")
	`DBF_ASSERT_NEXT(a_notice_stable, notice_valid && !notice_ready, $stable(notice), "notice changed while stalled")
	// remaining notices of a request follow without a gap
	`DBF_ASSERT_NEXT(a_notice_burst, notice_valid && notice_ready && !notice.last, notice_valid, "notice burst broken before last")
	// with nothing waiting at the output a request is always taken
	`DBF_ASSERT_NOW(a_ready_when_empty, !notice_valid, item_ready, "request refused with empty output")

endmodule

bind button_debounce_fsm dbf_checker u_dbf_checker (.*);
